// File: rtl/drp_pkg.sv
package drp_pkg;

    localparam int X_W      = 8;
    localparam int Y_W      = 9;
    localparam int STRIDE_W = 8;
    localparam int COUNT_W  = 8;
    localparam int AREA_W   = 17;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;

    localparam logic [X_W-1:0] PANEL_WIDTH  = 8'd122;
    localparam logic [Y_W-1:0] PANEL_HEIGHT = 9'd250;

    localparam logic [COUNT_W-1:0] PARTIAL_LIMIT_RESET = 8'd50;
    localparam logic [AREA_W-1:0]  MAX_PARTIAL_RESET   = 17'd30500;

    // x must sit on a byte boundary
    localparam logic [2:0] BYTE_MASK = 3'h7;

    localparam logic [CFG_IDX_W-1:0] CFG_PARTIAL_LIMIT      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PARTIAL_PIXELS = 1'd1;

    typedef enum logic [2:0] {
        OP_INIT    = 3'd0,
        OP_WRITE   = 3'd1,
        OP_PRESENT = 3'd2,
        OP_SLEEP   = 3'd3,
        OP_WAKE    = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_PARTIAL = 2'd1,
        KIND_FULL    = 2'd2
    } kind_t;

    localparam logic [1:0] MODE_FULL    = 2'd0;
    localparam logic [1:0] MODE_PARTIAL = 2'd1;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef struct packed {
        logic [2:0]          op;
        logic [X_W-1:0]      x;
        logic [Y_W-1:0]      y;
        logic [X_W-1:0]      w;
        logic [Y_W-1:0]      h;
        logic [STRIDE_W-1:0] stride;
        logic [1:0]          mode;
    } cmd_t;

    typedef struct packed {
        logic           status;
        logic [1:0]     kind;
        logic [X_W-1:0] x;
        logic [Y_W-1:0] y;
        logic [X_W-1:0] w;
        logic [Y_W-1:0] h;
    } res_t;

    typedef struct packed {
        logic [COUNT_W-1:0] partial_limit;
        logic [AREA_W-1:0]  max_partial_pixels;
    } cfg_t;

endpackage

// File: rtl/dirty_region_refresh_policy.sv
// Dirty-rectangle refresh policy for an e-paper panel.
//
// Input channel (in_valid / in_ready) carries one command beat: op plus the
// rectangle, stride and refresh mode. Every command beat gives exactly one
// result beat on the output channel (out_valid / out_ready): status, refresh
// kind and the region to refresh.
// Configuration channel (cfg_valid / cfg_ready) writes partial_limit
// (index 0) or max_partial_pixels (index 1); it is always ready. The user
// must write it only while the block is idle; the block does not enforce it.
//
// An accepted command is held in the input register, decided by the
// combinational policy logic once the output register is free or draining,
// and the result lands in the output register with the state update. The
// block takes one command per cycle while the receiver keeps out_ready high;
// the policy state updates on the same edge that loads the result.
// Reset clears all policy flags and the dirty box, empties both pipeline
// registers, and loads the configuration defaults (50 partials, 30500 pixels).
// When the receiver stalls, the result beat holds in the output register,
// the pending command holds in the input register, and in_ready drops once
// both are full.
module dirty_region_refresh_policy
    import drp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [2:0]            op,
    input  logic [X_W-1:0]        area_x,
    input  logic [Y_W-1:0]        area_y,
    input  logic [X_W-1:0]        area_width,
    input  logic [Y_W-1:0]        area_height,
    input  logic [STRIDE_W-1:0]   row_stride_bytes,
    input  logic [1:0]            refresh_mode,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  status,
    output logic [1:0]            refresh_kind,
    output logic [X_W-1:0]        region_x,
    output logic [Y_W-1:0]        region_y,
    output logic [X_W-1:0]        region_width,
    output logic [Y_W-1:0]        region_height,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg_reg;
    cmd_t cmd_reg;
    logic cmd_valid_reg;
    res_t res;
    res_t res_reg;
    logic out_valid_reg;
    logic fire;

    // Decide the held command when the output register is free or draining.
    assign fire      = cmd_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !cmd_valid_reg || fire;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.partial_limit      <= PARTIAL_LIMIT_RESET;
            cfg_reg.max_partial_pixels <= MAX_PARTIAL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PARTIAL_LIMIT:
                    cfg_reg.partial_limit <= cfg_data[COUNT_W-1:0];
                CFG_MAX_PARTIAL_PIXELS:
                    cfg_reg.max_partial_pixels <= cfg_data[AREA_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Input register: advance on an accepted beat, drop once decided.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            cmd_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            cmd_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg.op     <= op;
            cmd_reg.x      <= area_x;
            cmd_reg.y      <= area_y;
            cmd_reg.w      <= area_width;
            cmd_reg.h      <= area_height;
            cmd_reg.stride <= row_stride_bytes;
            cmd_reg.mode   <= refresh_mode;
        end
    end

    drp_policy u_policy (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .cmd   (cmd_reg),
        .cfg   (cfg_reg),
        .res   (res)
    );

    // Output register: load a fresh decision, hold while stalled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = res_reg.status;
    assign refresh_kind  = res_reg.kind;
    assign region_x      = res_reg.x;
    assign region_y      = res_reg.y;
    assign region_width  = res_reg.w;
    assign region_height = res_reg.h;

    // An empty output register never blocks the input side.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input blocked with empty output register");

    // No refresh means an all-zero region.
    a_none_zero_region: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && refresh_kind == KIND_NONE) |->
        (region_x == '0 && region_y == '0 && region_width == '0 && region_height == '0))
        else $error("region set without a refresh");

    // A full refresh covers the whole panel from the origin.
    a_full_panel: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && refresh_kind == KIND_FULL) |->
        (region_x == '0 && region_y == '0 && region_width == PANEL_WIDTH
            && region_height == PANEL_HEIGHT))
        else $error("full refresh not panel sized");

    // A rejected command never refreshes.
    a_err_no_refresh: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == STATUS_ERR) |-> (refresh_kind == KIND_NONE))
        else $error("refresh issued for rejected command");

endmodule

// File: rtl/drp_rect_check.sv
module drp_rect_check
    import drp_pkg::*;
(
    input  logic [X_W-1:0]      x,
    input  logic [Y_W-1:0]      y,
    input  logic [X_W-1:0]      w,
    input  logic [Y_W-1:0]      h,
    input  logic [STRIDE_W-1:0] stride,
    output logic                ok
);

    logic [X_W:0]   x_end;
    logic [Y_W:0]   y_end;
    logic [X_W-3:0] min_stride;

    always_comb
    begin
        x_end      = {1'b0, x} + {1'b0, w};
        y_end      = {1'b0, y} + {1'b0, h};
        // ceil(w / 8) fits five bits for every width that the panel bound accepts
        min_stride = {1'b0, w[X_W-1:3]} + {{(X_W-3){1'b0}}, |w[2:0]};
        ok = (w != '0) && (h != '0)
            && ((x[2:0] & BYTE_MASK) == 3'd0)
            && (x_end <= {1'b0, PANEL_WIDTH})
            && (y_end <= {1'b0, PANEL_HEIGHT})
            && (stride >= {2'b00, min_stride});
    end

endmodule

// File: rtl/drp_policy.sv
module drp_policy
    import drp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic fire,
    input  cmd_t cmd,
    input  cfg_t cfg,
    output res_t res
);

    logic               init_done_reg, init_done_next;
    logic               asleep_reg, asleep_next;
    logic               dirty_reg, dirty_next;
    logic               base_valid_reg, base_valid_next;
    logic [COUNT_W-1:0] pcount_reg, pcount_next;
    logic [X_W-1:0]     left_reg, left_next;
    logic [Y_W-1:0]     top_reg, top_next;
    logic [X_W-1:0]     wide_reg, wide_next;
    logic [Y_W-1:0]     tall_reg, tall_next;

    logic              rect_ok;
    logic [AREA_W-1:0] box_area;
    logic [X_W-1:0]    m_left;
    logic [Y_W-1:0]    m_top;
    logic [X_W:0]      m_right;
    logic [Y_W:0]      m_bottom;
    logic [X_W:0]      m_wide;
    logic [Y_W:0]      m_tall;

    drp_rect_check u_rect (
        .x      (cmd.x),
        .y      (cmd.y),
        .w      (cmd.w),
        .h      (cmd.h),
        .stride (cmd.stride),
        .ok     (rect_ok)
    );

    assign box_area = AREA_W'(wide_reg) * AREA_W'(tall_reg);

    // bounding box of the held box and the new rectangle
    always_comb
    begin
        m_left   = (left_reg < cmd.x) ? left_reg : cmd.x;
        m_top    = (top_reg < cmd.y) ? top_reg : cmd.y;
        m_right  = {1'b0, left_reg} + {1'b0, wide_reg};
        if (({1'b0, cmd.x} + {1'b0, cmd.w}) > m_right)
        begin
            m_right = {1'b0, cmd.x} + {1'b0, cmd.w};
        end
        m_bottom = {1'b0, top_reg} + {1'b0, tall_reg};
        if (({1'b0, cmd.y} + {1'b0, cmd.h}) > m_bottom)
        begin
            m_bottom = {1'b0, cmd.y} + {1'b0, cmd.h};
        end
        m_wide = m_right - {1'b0, m_left};
        m_tall = m_bottom - {1'b0, m_top};
    end

    always_comb
    begin
        init_done_next  = init_done_reg;
        asleep_next     = asleep_reg;
        dirty_next      = dirty_reg;
        base_valid_next = base_valid_reg;
        pcount_next     = pcount_reg;
        left_next       = left_reg;
        top_next        = top_reg;
        wide_next       = wide_reg;
        tall_next       = tall_reg;
        res             = '0;
        res.status      = STATUS_ERR;
        res.kind        = KIND_NONE;

        case (cmd.op)
            OP_INIT:
            begin
                if (!init_done_reg)
                begin
                    init_done_next  = 1'b1;
                    asleep_next     = 1'b0;
                    dirty_next      = 1'b0;
                    base_valid_next = 1'b0;
                    pcount_next     = '0;
                end
                res.status = STATUS_OK;
            end
            OP_WRITE:
            begin
                if (init_done_reg && !asleep_reg && rect_ok)
                begin
                    dirty_next = 1'b1;
                    if (!dirty_reg)
                    begin
                        left_next = cmd.x;
                        top_next  = cmd.y;
                        wide_next = cmd.w;
                        tall_next = cmd.h;
                    end
                    else
                    begin
                        left_next = m_left;
                        top_next  = m_top;
                        wide_next = m_wide[X_W-1:0];
                        tall_next = m_tall[Y_W-1:0];
                    end
                    res.status = STATUS_OK;
                end
            end
            OP_PRESENT:
            begin
                if (init_done_reg && !asleep_reg)
                begin
                    if (!dirty_reg)
                    begin
                        res.status = STATUS_OK;
                    end
                    else if (cmd.mode inside {MODE_FULL, MODE_PARTIAL})
                    begin
                        if ((cmd.mode == MODE_PARTIAL) && base_valid_reg
                            && (box_area <= cfg.max_partial_pixels)
                            && (pcount_reg < cfg.partial_limit))
                        begin
                            res.kind    = KIND_PARTIAL;
                            res.x       = left_reg;
                            res.y       = top_reg;
                            res.w       = wide_reg;
                            res.h       = tall_reg;
                            pcount_next = pcount_reg + 1'b1;
                        end
                        else
                        begin
                            res.kind        = KIND_FULL;
                            res.w           = PANEL_WIDTH;
                            res.h           = PANEL_HEIGHT;
                            base_valid_next = 1'b1;
                            pcount_next     = '0;
                        end
                        dirty_next = 1'b0;
                        res.status = STATUS_OK;
                    end
                end
            end
            OP_SLEEP:
            begin
                if (init_done_reg)
                begin
                    asleep_next     = 1'b1;
                    base_valid_next = 1'b0;
                    res.status      = STATUS_OK;
                end
            end
            OP_WAKE:
            begin
                if (init_done_reg)
                begin
                    if (asleep_reg)
                    begin
                        asleep_next     = 1'b0;
                        dirty_next      = 1'b0;
                        base_valid_next = 1'b0;
                        pcount_next     = '0;
                    end
                    res.status = STATUS_OK;
                end
            end
            default:
            begin
                res.status = STATUS_ERR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_done_reg  <= 1'b0;
            asleep_reg     <= 1'b0;
            dirty_reg      <= 1'b0;
            base_valid_reg <= 1'b0;
            pcount_reg     <= '0;
            left_reg       <= '0;
            top_reg        <= '0;
            wide_reg       <= '0;
            tall_reg       <= '0;
        end
        else if (fire)
        begin
            init_done_reg  <= init_done_next;
            asleep_reg     <= asleep_next;
            dirty_reg      <= dirty_next;
            base_valid_reg <= base_valid_next;
            pcount_reg     <= pcount_next;
            left_reg       <= left_next;
            top_reg        <= top_next;
            wide_reg       <= wide_next;
            tall_reg       <= tall_next;
        end
    end

endmodule

// File: bench/refresh_scoreboard_pkg.sv
package refresh_scoreboard_pkg;
    import drp_pkg::*;

    class refresh_scoreboard;
        logic [COUNT_W-1:0] limit_cfg;
        logic [AREA_W-1:0]  pixel_cap;

        bit                 is_init;
        bit                 asleep;
        bit                 dirty;
        bit                 base_ok;
        logic [COUNT_W-1:0] partials;
        logic [X_W-1:0]     box_l;
        logic [X_W-1:0]     box_w;
        logic [Y_W-1:0]     box_t;
        logic [Y_W-1:0]     box_h;

        res_t expected_q[$];

        int fails;
        int commands;
        int partial_seen;
        int full_seen;
        int rejects;

        function new();
            limit_cfg    = PARTIAL_LIMIT_RESET;
            pixel_cap    = MAX_PARTIAL_RESET;
            is_init      = 1'b0;
            asleep       = 1'b0;
            dirty        = 1'b0;
            base_ok      = 1'b0;
            partials     = '0;
            box_l        = '0;
            box_w        = '0;
            box_t        = '0;
            box_h        = '0;
            fails        = 0;
            commands     = 0;
            partial_seen = 0;
            full_seen    = 0;
            rejects      = 0;
        endfunction

        function void end_session();
            asleep   = 1'b0;
            dirty    = 1'b0;
            base_ok  = 1'b0;
            partials = '0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_PARTIAL_LIMIT)
            begin
                limit_cfg = data[COUNT_W-1:0];
            end
            else
            begin
                pixel_cap = data[AREA_W-1:0];
            end
        endfunction

        // Work out the result of one accepted command and queue it.
        function void note_command(cmd_t c);
            res_t r;
            bit   fits;
            int   left;
            int   top;
            int   right;
            int   bottom;

            r        = '0;
            r.status = STATUS_ERR;
            r.kind   = KIND_NONE;
            case (c.op)
                OP_INIT:
                begin
                    if (!is_init)
                    begin
                        is_init = 1'b1;
                        end_session();
                    end
                    r.status = STATUS_OK;
                end
                OP_WRITE:
                begin
                    fits = c.w != '0 && c.h != '0 && (c.x[2:0] & BYTE_MASK) == 3'd0 &&
                           int'(c.x) + int'(c.w) <= int'(PANEL_WIDTH) &&
                           int'(c.y) + int'(c.h) <= int'(PANEL_HEIGHT) &&
                           int'(c.stride) >= (int'(c.w) + 7) / 8;
                    if (is_init && !asleep && fits)
                    begin
                        if (!dirty)
                        begin
                            box_l = c.x;
                            box_t = c.y;
                            box_w = c.w;
                            box_h = c.h;
                            dirty = 1'b1;
                        end
                        else
                        begin
                            left   = box_l < c.x ? int'(box_l) : int'(c.x);
                            top    = box_t < c.y ? int'(box_t) : int'(c.y);
                            right  = int'(box_l) + int'(box_w);
                            bottom = int'(box_t) + int'(box_h);
                            if (int'(c.x) + int'(c.w) > right)
                                right = int'(c.x) + int'(c.w);
                            if (int'(c.y) + int'(c.h) > bottom)
                                bottom = int'(c.y) + int'(c.h);
                            box_l = X_W'(left);
                            box_t = Y_W'(top);
                            box_w = X_W'(right - left);
                            box_h = Y_W'(bottom - top);
                        end
                        r.status = STATUS_OK;
                    end
                end
                OP_PRESENT:
                begin
                    if (is_init && !asleep)
                    begin
                        if (!dirty)
                        begin
                            r.status = STATUS_OK;
                        end
                        else if (c.mode == MODE_FULL || c.mode == MODE_PARTIAL)
                        begin
                            if (c.mode == MODE_PARTIAL && base_ok &&
                                int'(box_w) * int'(box_h) <= int'(pixel_cap) &&
                                partials < limit_cfg)
                            begin
                                r.kind   = KIND_PARTIAL;
                                r.x      = box_l;
                                r.y      = box_t;
                                r.w      = box_w;
                                r.h      = box_h;
                                partials = partials + 1'b1;
                                partial_seen++;
                            end
                            else
                            begin
                                r.kind   = KIND_FULL;
                                r.w      = PANEL_WIDTH;
                                r.h      = PANEL_HEIGHT;
                                base_ok  = 1'b1;
                                partials = '0;
                                full_seen++;
                            end
                            dirty    = 1'b0;
                            r.status = STATUS_OK;
                        end
                    end
                end
                OP_SLEEP:
                begin
                    if (is_init)
                    begin
                        asleep   = 1'b1;
                        base_ok  = 1'b0;
                        r.status = STATUS_OK;
                    end
                end
                OP_WAKE:
                begin
                    if (is_init)
                    begin
                        if (asleep)
                            end_session();
                        r.status = STATUS_OK;
                    end
                end
                default:
                begin
                end
            endcase
            if (r.status == STATUS_ERR)
                rejects++;
            commands++;
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                fails++;
            end
        endfunction

        function void check_result(res_t got);
            res_t want;

            if (expected_q.size() == 0)
            begin
                $error("result beat arrived with no command outstanding");
                fails++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("status", 16'(want.status), 16'(got.status));
            compare_field("refresh_kind", 16'(want.kind), 16'(got.kind));
            compare_field("region_x", 16'(want.x), 16'(got.x));
            compare_field("region_y", 16'(want.y), 16'(got.y));
            compare_field("region_width", 16'(want.w), 16'(got.w));
            compare_field("region_height", 16'(want.h), 16'(got.h));
        endfunction
    endclass

endpackage

// File: bench/tb_top.sv
module tb_top;
    import drp_pkg::*;
    import refresh_scoreboard_pkg::*;

    // Generous ceiling for the ~600 beats of the run.
    localparam int CYCLE_LIMIT   = 200000;
    localparam int ITEMS_PER_SET = 82;
    localparam int SET_COUNT     = 7;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                  in_valid;
    logic                  in_ready;
    logic [2:0]            op;
    logic [X_W-1:0]        area_x;
    logic [Y_W-1:0]        area_y;
    logic [X_W-1:0]        area_width;
    logic [Y_W-1:0]        area_height;
    logic [STRIDE_W-1:0]   row_stride_bytes;
    logic [1:0]            refresh_mode;

    logic                  out_valid;
    logic                  out_ready;
    logic                  status;
    logic [1:0]            refresh_kind;
    logic [X_W-1:0]        region_x;
    logic [Y_W-1:0]        region_y;
    logic [X_W-1:0]        region_width;
    logic [Y_W-1:0]        region_height;

    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Per-phase switches: when clear, that side runs flat out with no gaps.
    bit send_idle;
    bit recv_idle;
    int cycle_count = 0;

    refresh_scoreboard sb = new();

    dirty_region_refresh_policy u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .op               (op),
        .area_x           (area_x),
        .area_y           (area_y),
        .area_width       (area_width),
        .area_height      (area_height),
        .row_stride_bytes (row_stride_bytes),
        .refresh_mode     (refresh_mode),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .refresh_kind     (refresh_kind),
        .region_x         (region_x),
        .region_y         (region_y),
        .region_width     (region_width),
        .region_height    (region_height),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("** dirty_region_refresh_policy: FAILED **");
            $finish;
        end
    end

    // Monitors. All three sample the pre-edge values of valid, ready and the
    // payload, so they see exactly the beat that the edge moves.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_command({op, area_x, area_y, area_width, area_height,
                             row_stride_bytes, refresh_mode});
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result({status, refresh_kind, region_x, region_y,
                             region_width, region_height});
    end

    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
            sb.write_register(cfg_index, cfg_data);
    end

    // Result side: draw a stall before every beat, then hold ready high until
    // a beat goes through. A zero stall keeps ready high without a glitch.
    initial
    begin
        int stall;

        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = recv_idle ? $urandom_range(0, 12) : 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    function automatic cmd_t build_cmd(logic [2:0] o, int x, int y, int w, int h,
                                       int s, int m);
        cmd_t c;

        c.op     = o;
        c.x      = X_W'(x);
        c.y      = Y_W'(y);
        c.w      = X_W'(w);
        c.h      = Y_W'(h);
        c.stride = STRIDE_W'(s);
        c.mode   = 2'(m);
        return c;
    endfunction

    // Mostly well-formed traffic: legal rectangles (usually small, so the box
    // stays under the pixel cap) and presents that ask for a partial refresh.
    // The rest is broken rectangles, bad modes, power commands and noise.
    function automatic cmd_t draw_command();
        cmd_t c;
        int   pick;
        int   span;
        int   flavour;

        c.op     = 3'($urandom_range(0, 7));
        c.x      = X_W'($urandom);
        c.y      = Y_W'($urandom);
        c.w      = X_W'($urandom);
        c.h      = Y_W'($urandom);
        c.stride = STRIDE_W'($urandom);
        c.mode   = 2'($urandom);
        pick     = $urandom_range(0, 99);
        if (pick < 45)
        begin
            c.op = OP_WRITE;
            c.x  = X_W'(8 * $urandom_range(0, 15));
            span = int'(PANEL_WIDTH) - int'(c.x);
            if ($urandom_range(0, 3) != 0 && span > 24)
                span = 24;
            c.w  = X_W'($urandom_range(1, span));
            c.y  = Y_W'($urandom_range(0, int'(PANEL_HEIGHT) - 1));
            span = int'(PANEL_HEIGHT) - int'(c.y);
            if ($urandom_range(0, 3) != 0 && span > 32)
                span = 32;
            c.h      = Y_W'($urandom_range(1, span));
            c.stride = STRIDE_W'($urandom_range((int'(c.w) + 7) / 8, 255));
        end
        else if (pick < 55)
        begin
            // random rectangle: nearly always rejected
            c.op = OP_WRITE;
        end
        else if (pick < 83)
        begin
            c.op    = OP_PRESENT;
            flavour = $urandom_range(0, 19);
            c.mode  = flavour < 14 ? MODE_PARTIAL :
                      flavour < 17 ? MODE_FULL : 2'($urandom_range(2, 3));
        end
        else if (pick < 86)
        begin
            c.op = OP_INIT;
        end
        else if (pick < 89)
        begin
            c.op = OP_SLEEP;
        end
        else if (pick < 95)
        begin
            c.op = OP_WAKE;
        end
        return c;
    endfunction

    // Drive one command beat. Drop valid only when a gap is drawn; otherwise
    // the next beat follows straight on with valid held high.
    task automatic push_command(input cmd_t c);
        int gap;

        gap = send_idle ? $urandom_range(0, 12) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid         <= 1'b1;
        op               <= c.op;
        area_x           <= c.x;
        area_y           <= c.y;
        area_width       <= c.w;
        area_height      <= c.h;
        row_stride_bytes <= c.stride;
        refresh_mode     <= c.mode;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Stop sending, let every outstanding result drain, then let the
    // two-stage pipeline go quiet.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write both registers in one burst; valid stays high between the beats.
    task automatic program_limits(input int lim, input int cap);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_PARTIAL_LIMIT;
        // upper bits are junk: only the low byte of the limit counts
        cfg_data  <= {9'($urandom), 8'(lim)};
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_index <= CFG_MAX_PARTIAL_PIXELS;
        cfg_data  <= CFG_DATA_W'(cap);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int limit_set[SET_COUNT];
        int cap_set[SET_COUNT];

        // First phase keeps the reset values; the rest walk the extremes.
        limit_set = '{50, 0, 255, 1, 3, 255, 2};
        cap_set   = '{30500, 131071, 0, 200, 131071, 131071, 1500};

        in_valid         <= 1'b0;
        op               <= OP_INIT;
        area_x           <= '0;
        area_y           <= '0;
        area_width       <= '0;
        area_height      <= '0;
        row_stride_bytes <= '0;
        refresh_mode     <= MODE_FULL;
        cfg_valid        <= 1'b0;
        cfg_index        <= CFG_PARTIAL_LIMIT;
        cfg_data         <= '0;
        send_idle        = 1'b1;
        recv_idle        = 1'b1;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pass at reset configuration.
        // Everything but init is refused before the panel is brought up.
        push_command(build_cmd(OP_WRITE, 0, 0, 8, 8, 1, MODE_FULL));
        push_command(build_cmd(OP_PRESENT, 0, 0, 0, 0, 0, MODE_PARTIAL));
        push_command(build_cmd(OP_SLEEP, 0, 0, 0, 0, 0, MODE_FULL));
        push_command(build_cmd(OP_WAKE, 0, 0, 0, 0, 0, MODE_FULL));
        push_command(build_cmd(3'd7, 255, 511, 255, 511, 255, 3));
        // Bring up, then a second init that must change nothing.
        push_command(build_cmd(OP_INIT, 0, 0, 0, 0, 0, MODE_FULL));
        push_command(build_cmd(OP_INIT, 0, 0, 0, 0, 0, MODE_FULL));
        // Present with nothing dirty passes even with a bad mode.
        push_command(build_cmd(OP_PRESENT, 0, 0, 0, 0, 0, 3));
        // Broken rectangles: zero size, off-byte x, past either edge, short stride.
        push_command(build_cmd(OP_WRITE, 0, 0, 0, 8, 1, MODE_FULL));
        push_command(build_cmd(OP_WRITE, 0, 0, 8, 0, 1, MODE_FULL));
        push_command(build_cmd(OP_WRITE, 4, 0, 8, 8, 1, MODE_FULL));
        push_command(build_cmd(OP_WRITE, 120, 0, 8, 8, 1, MODE_FULL));
        push_command(build_cmd(OP_WRITE, 0, 200, 8, 51, 1, MODE_FULL));
        push_command(build_cmd(OP_WRITE, 0, 0, 17, 4, 2, MODE_FULL));
        push_command(build_cmd(OP_WRITE, 255, 511, 255, 511, 255, 3));
        // Whole panel with the tightest stride, then a refused bad mode.
        push_command(build_cmd(OP_WRITE, 0, 0, 122, 250, 16, MODE_FULL));
        push_command(build_cmd(OP_PRESENT, 0, 0, 0, 0, 0, 2));
        push_command(build_cmd(OP_PRESENT, 0, 0, 0, 0, 0, MODE_FULL));
        // Base frame now valid: a small box refreshes partially.
        push_command(build_cmd(OP_WRITE, 16, 10, 8, 4, 1, MODE_FULL));
        push_command(build_cmd(OP_PRESENT, 0, 0, 0, 0, 0, MODE_PARTIAL));
        // Two rectangles merge into one box reaching the far corner.
        push_command(build_cmd(OP_WRITE, 8, 100, 16, 20, 2, MODE_FULL));
        push_command(build_cmd(OP_WRITE, 112, 249, 10, 1, 2, MODE_FULL));
        push_command(build_cmd(OP_PRESENT, 0, 0, 0, 0, 0, MODE_PARTIAL));
        // Asleep: a write is refused; wake clears the session.
        push_command(build_cmd(OP_SLEEP, 0, 0, 0, 0, 0, MODE_FULL));
        push_command(build_cmd(OP_WRITE, 0, 0, 8, 8, 1, MODE_FULL));
        push_command(build_cmd(OP_WAKE, 0, 0, 0, 0, 0, MODE_FULL));
        push_command(build_cmd(OP_WAKE, 0, 0, 0, 0, 0, MODE_FULL));
        // No base frame after wake, so a partial request turns full.
        push_command(build_cmd(OP_WRITE, 0, 0, 8, 8, 1, MODE_FULL));
        push_command(build_cmd(OP_PRESENT, 0, 0, 0, 0, 0, MODE_PARTIAL));
        settle();

        // Random phases, one per register setting.
        for (int s = 0; s < SET_COUNT; s++)
        begin
            if (s > 0)
                program_limits(limit_set[s], cap_set[s]);
            send_idle = $urandom_range(0, 3) != 0;
            recv_idle = $urandom_range(0, 3) != 0;
            for (int i = 0; i < ITEMS_PER_SET; i++)
                push_command(draw_command());
            settle();
        end

        $display("Checked %0d commands over %0d register settings: %0d partial and %0d full refreshes.",
                 sb.commands, SET_COUNT, sb.partial_seen, sb.full_seen);
        $display("%0d commands were rejected; %0d mismatches seen.", sb.rejects, sb.fails);
        if (sb.fails == 0)
        begin
            $display("** dirty_region_refresh_policy: PASSED **");
        end
        else
        begin
            $display("** dirty_region_refresh_policy: FAILED **");
        end
        $finish;
    end

endmodule
